// ===== src/refcounted_key_intern_table_assert.svh =====
// Assertion macros used by the checker file.
`ifndef REFCOUNTED_KEY_INTERN_TABLE_ASSERT_SVH
`define REFCOUNTED_KEY_INTERN_TABLE_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RITAB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ritab: implication check failed");

// Next-cycle implication, off while reset is high.
`define RITAB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ritab: next-cycle check failed");

`endif

// ===== src/ritab_pkg.sv =====
`default_nettype none

package ritab_pkg;

   localparam int SLOTS      = 16;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int KEY_W        = 32;
   localparam int RSP_SLOT_W   = 4;
   localparam int RSP_COUNT_W  = 16;
   localparam int RSP_STATUS_W = 3;

   // Request kinds
   localparam logic KIND_ACQUIRE = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [RSP_STATUS_W-1:0] {
      ST_NEW       = 3'd0,
      ST_MATCHED   = 3'd1,
      ST_FULL      = 3'd2,
      ST_RELEASED  = 3'd3,
      ST_FREED     = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_SATURATED = 3'd6
   } status_type;

   // Count write from the sequencer into the count file
   typedef struct packed {
      logic                  en;
      logic [SLOT_W-1:0]     idx;
      logic [COUNT_BITS-1:0] value;
   } cnt_wr_type;

endpackage

`default_nettype wire

// ===== src/refcounted_key_intern_table.sv =====
// Reference-counted key intern table, 16 slots.
// Flow: the start transfer is followed by a scan of every slot, an update of
// the chosen slot, and the registered result on the ports.
// A new request is taken only while idle; the scan reads one slot per cycle
// through the key RAM port and the single key compare.
// Reset: synchronous, active high; all counts cleared at once, keys left as is.
// The receiver cannot stall: rsp_valid marks each result for exactly one cycle.
`default_nettype none

module refcounted_key_intern_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_kind,
   input  wire logic [ritab_pkg::KEY_W-1:0]         req_date_key,
   output logic                                     rsp_valid,
   output logic      [ritab_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   output logic      [ritab_pkg::RSP_COUNT_W-1:0]   rsp_ref_count,
   output logic      [ritab_pkg::RSP_STATUS_W-1:0]  rsp_status
);

   import ritab_pkg::*;

   localparam logic [SLOT_W-1:0]     LAST_IDX = SLOT_W'(SLOTS - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

   // Sequencer state and latched request
   state_type             state_ff,      state_in;
   logic [SLOT_W-1:0]     idx_ff,        idx_in;
   logic                  kind_ff,       kind_in;
   logic [KEY_W-1:0]      key_ff,        key_in;

   // Scan results: first live match and lowest free slot
   logic                  hit_found_ff,  hit_found_in;
   logic [SLOT_W-1:0]     hit_idx_ff,    hit_idx_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff,    hit_cnt_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_idx_ff,   free_idx_in;

   // Result registers
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [RSP_SLOT_W-1:0]   rsp_slot_ff,   rsp_slot_in;
   logic [RSP_COUNT_W-1:0]  rsp_count_ff,  rsp_count_in;
   status_type              rsp_status_ff, rsp_status_in;

   // Storage ports
   logic [KEY_W-1:0]      key_rd;
   logic                  key_we;
   logic [COUNT_BITS-1:0] cnt_rd;
   cnt_wr_type            cnt_wr;

   // Shared compare unit
   logic                  slot_live;
   logic                  slot_match;
   logic [COUNT_BITS-1:0] cnt_dec;

   // Key RAM: read address runs one step ahead so the key of idx_ff
   // is on rd_data during each scan cycle.
   ritab_ram #(
      .WIDTH (KEY_W),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_addr (idx_in),
      .rd_data (key_rd)
   );

   ritab_counts u_counts (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .rd_count (cnt_rd),
      .wr       (cnt_wr)
   );

   // A stored key counts only while its slot is live.
   assign slot_live  = (cnt_rd != '0);
   assign slot_match = slot_live && (key_rd == key_ff);
   assign cnt_dec    = hit_cnt_ff - CNT_ONE;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      key_we        = 1'b0;
      cnt_wr        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in       = req_kind;
               key_in        = req_date_key;
               idx_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end

         S_SCAN: begin
            if (slot_match && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = idx_ff;
               hit_cnt_in   = cnt_rd;
            end
            if (!slot_live && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_UPDATE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         S_UPDATE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (kind_ff == KIND_ACQUIRE) begin
               if (hit_found_ff) begin
                  rsp_slot_in = RSP_SLOT_W'(hit_idx_ff);
                  if (hit_cnt_ff == CNT_MAX) begin
                     // count pinned at its maximum, table unchanged
                     rsp_count_in  = RSP_COUNT_W'(hit_cnt_ff);
                     rsp_status_in = ST_SATURATED;
                  end else begin
                     cnt_wr.en     = 1'b1;
                     cnt_wr.idx    = hit_idx_ff;
                     cnt_wr.value  = hit_cnt_ff + CNT_ONE;
                     rsp_count_in  = RSP_COUNT_W'(hit_cnt_ff + CNT_ONE);
                     rsp_status_in = ST_MATCHED;
                  end
               end else if (free_found_ff) begin
                  key_we        = 1'b1;
                  cnt_wr.en     = 1'b1;
                  cnt_wr.idx    = free_idx_ff;
                  cnt_wr.value  = CNT_ONE;
                  rsp_slot_in   = RSP_SLOT_W'(free_idx_ff);
                  rsp_count_in  = RSP_COUNT_W'(CNT_ONE);
                  rsp_status_in = ST_NEW;
               end else begin
                  rsp_slot_in   = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = ST_FULL;
               end
            end else begin
               if (hit_found_ff) begin
                  cnt_wr.en    = 1'b1;
                  cnt_wr.idx   = hit_idx_ff;
                  cnt_wr.value = cnt_dec;
                  rsp_slot_in  = RSP_SLOT_W'(hit_idx_ff);
                  rsp_count_in = RSP_COUNT_W'(cnt_dec);
                  if (cnt_dec == '0) begin
                     rsp_status_in = ST_FREED;
                  end else begin
                     rsp_status_in = ST_RELEASED;
                  end
               end else begin
                  rsp_slot_in   = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_cnt_ff    <= hit_cnt_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_ref_count = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

// ===== src/ritab_ram.sv =====
`default_nettype none

module ritab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/ritab_counts.sv =====
`default_nettype none

module ritab_counts (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [ritab_pkg::SLOT_W-1:0]      rd_idx,
   output logic      [ritab_pkg::COUNT_BITS-1:0]  rd_count,
   input  wire ritab_pkg::cnt_wr_type             wr
);

   import ritab_pkg::*;

   // Per-slot reference counts; zero marks a free slot.
   logic [COUNT_BITS-1:0] counts_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (wr.en) begin
         counts_ff[wr.idx] <= wr.value;
      end
   end

   assign rd_count = counts_ff[rd_idx];

endmodule

`default_nettype wire

// ===== src/ritab_checker.sv =====
`default_nettype none

`include "refcounted_key_intern_table_assert.svh"

module ritab_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                rsp_valid,
   input  wire logic [ritab_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   input  wire logic [ritab_pkg::RSP_COUNT_W-1:0]   rsp_ref_count,
   input  wire logic [ritab_pkg::RSP_STATUS_W-1:0]  rsp_status
);

   import ritab_pkg::*;

   logic accept;
   logic rsp_empty;

   assign accept    = start && !busy;
   assign rsp_empty = (rsp_status == ST_FULL) || (rsp_status == ST_NOT_FOUND);

   `RITAB_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `RITAB_ASSERT_IMP(a_accept_latency, clock, reset, accept, ##18 rsp_valid)
   `RITAB_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `RITAB_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `RITAB_ASSERT_IMP(a_empty_rsp, clock, reset, rsp_valid && rsp_empty,
                     (rsp_slot == '0) && (rsp_ref_count == '0))

endmodule

bind refcounted_key_intern_table ritab_checker u_ritab_checker (.*);

`default_nettype wire

// ===== sim/tb_refcounted_key_intern_table.sv =====
`timescale 1ns / 100ps

module tb_refcounted_key_intern_table;
   import ritab_pkg::*;

   // Result transfer trails the start transfer by the slot scan, the update
   // and the register that shows the result.
   localparam int RSP_LATENCY = 18;
   // About 520 transfers, each with its gap; the limit leaves a wide margin.
   localparam int CYCLE_LIMIT = 100_000;
   localparam int RAND_OPS    = 500;
   localparam int PHASE_OPS   = 50;
   localparam int POOL_SIZE   = 20;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [RSP_SLOT_W-1:0]  slot;
      logic [RSP_COUNT_W-1:0] cnt;
      status_type             st;
   } intern_rsp_type;

   // One row of the directed table. When typed is clear the rsp field is
   // ignored and the shadow table supplies the expected result.
   typedef struct packed {
      logic           kind;
      logic [31:0]    key;
      logic           typed;
      intern_rsp_type rsp;
   } op_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_kind = KIND_ACQUIRE;
   logic [KEY_W-1:0] req_date_key = '0;

   logic                    busy;
   logic                    rsp_valid;
   logic [RSP_SLOT_W-1:0]   rsp_slot;
   logic [RSP_COUNT_W-1:0]  rsp_ref_count;
   logic [RSP_STATUS_W-1:0] rsp_status;

   refcounted_key_intern_table dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_date_key  (req_date_key),
      .rsp_valid     (rsp_valid),
      .rsp_slot      (rsp_slot),
      .rsp_ref_count (rsp_ref_count),
      .rsp_status    (rsp_status)
   );

   always #5 clock = ~clock;

   // Shadow copy of the table. Keys of free slots are never compared.
   logic [KEY_W-1:0]      shadow_key [SLOTS];
   logic [COUNT_BITS-1:0] shadow_cnt [SLOTS];

   intern_rsp_type awaited_rsp_q [$];
   int             mismatches = 0;
   int             cycles = 0;

   // Live slot holding key, or -1.
   function automatic int find_live(input logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_cnt[i] != '0 && shadow_key[i] == key) return i;
      end
      return -1;
   endfunction

   // Applies one acquire/release to the shadow table and returns its result.
   function automatic intern_rsp_type apply_intern_op(input logic kind,
                                                      input logic [KEY_W-1:0] key);
      intern_rsp_type r;
      int             hit;
      int             free_idx;
      hit = find_live(key);
      free_idx = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (shadow_cnt[i] == '0) free_idx = i;
      end
      r.slot = '0;
      r.cnt  = '0;
      if (kind == KIND_ACQUIRE) begin
         if (hit >= 0) begin
            r.slot = hit[RSP_SLOT_W-1:0];
            if (shadow_cnt[hit] == CNT_MAX) begin
               r.st = ST_SATURATED;
            end else begin
               shadow_cnt[hit] = shadow_cnt[hit] + 1'b1;
               r.st = ST_MATCHED;
            end
            r.cnt = shadow_cnt[hit][RSP_COUNT_W-1:0];
         end else if (free_idx < 0) begin
            r.st = ST_FULL;
         end else begin
            shadow_key[free_idx] = key;
            shadow_cnt[free_idx] = COUNT_BITS'(1);
            r.slot = free_idx[RSP_SLOT_W-1:0];
            r.cnt  = RSP_COUNT_W'(1);
            r.st   = ST_NEW;
         end
      end else begin
         if (hit < 0) begin
            r.st = ST_NOT_FOUND;
         end else begin
            shadow_cnt[hit] = shadow_cnt[hit] - 1'b1;
            r.slot = hit[RSP_SLOT_W-1:0];
            r.cnt  = shadow_cnt[hit][RSP_COUNT_W-1:0];
            r.st   = (shadow_cnt[hit] == '0) ? ST_FREED : ST_RELEASED;
         end
      end
      return r;
   endfunction

   // Drives one request and waits for its transfer. start stays high when
   // the next request follows with no gap, so it is lowered here only before a gap.
   task automatic send_op(input logic kind, input logic [KEY_W-1:0] key,
                          input bit typed, input intern_rsp_type typed_rsp,
                          input int gap);
      intern_rsp_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_kind     <= kind;
      req_date_key <= key;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_intern_op(kind, key);
      awaited_rsp_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Result checker: every strobe is one transfer, matched in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_rsp_q.size() == 0) begin
            $error("unexpected result: slot %0d ref_count %0d status %0d",
                   rsp_slot, rsp_ref_count, rsp_status);
            mismatches++;
         end else begin
            intern_rsp_type exp_rsp;
            exp_rsp = awaited_rsp_q.pop_front();
            if (rsp_slot !== exp_rsp.slot) begin
               $error("rsp_slot: expected %0d, got %0d", exp_rsp.slot, rsp_slot);
               mismatches++;
            end
            if (rsp_ref_count !== exp_rsp.cnt) begin
               $error("rsp_ref_count: expected %0d, got %0d", exp_rsp.cnt, rsp_ref_count);
               mismatches++;
            end
            if (rsp_status !== exp_rsp.st) begin
               $error("rsp_status: expected %0d, got %0d", exp_rsp.st, rsp_status);
               mismatches++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_refcounted_key_intern_table: FAIL");
         $finish;
      end
   end

   initial begin
      op_row_type       dir_rows [$];
      intern_rsp_type   no_rsp;
      logic [KEY_W-1:0] key_pool [POOL_SIZE];
      logic [KEY_W-1:0] key;
      logic             kind;
      bit               idle_on;
      bit               acq_heavy;
      int               live_idx [$];
      int               sel;
      int               gap;

      no_rsp = '0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_key[i] = '0;
         shadow_cnt[i] = '0;
      end

      // Directed table. Fill rows use the shadow table; the rest are
      // easy to work out by hand.
      //                    kind          key           typed slot   count   status
      dir_rows.push_back({KIND_RELEASE, 32'h0000_0000, 1'b1, 4'd0, 16'd0, ST_NOT_FOUND});
      dir_rows.push_back({KIND_ACQUIRE, 32'h0000_0000, 1'b1, 4'd0, 16'd1, ST_NEW});
      dir_rows.push_back({KIND_ACQUIRE, 32'hFFFF_FFFF, 1'b1, 4'd1, 16'd1, ST_NEW});
      dir_rows.push_back({KIND_ACQUIRE, 32'h0000_0000, 1'b1, 4'd0, 16'd2, ST_MATCHED});
      dir_rows.push_back({KIND_RELEASE, 32'hFFFF_FFFF, 1'b1, 4'd1, 16'd0, ST_FREED});
      dir_rows.push_back({KIND_RELEASE, 32'h0000_0000, 1'b1, 4'd0, 16'd1, ST_RELEASED});
      // freed slot 1 is the lowest free one again
      dir_rows.push_back({KIND_ACQUIRE, 32'hAAAA_AAAA, 1'b1, 4'd1, 16'd1, ST_NEW});
      dir_rows.push_back({KIND_ACQUIRE, 32'h5555_5555, 1'b1, 4'd2, 16'd1, ST_NEW});
      // stale key of a freed slot must not match
      dir_rows.push_back({KIND_RELEASE, 32'hFFFF_FFFF, 1'b1, 4'd0, 16'd0, ST_NOT_FOUND});
      // fill slots 3..15 (keys mostly one bit off other keys)
      dir_rows.push_back({KIND_ACQUIRE, 32'h8000_0000, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h4000_0000, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h2000_0000, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h0000_0001, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h0000_0002, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h0001_0000, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'hFFFF_FFFE, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h7FFF_FFFF, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'hAAAA_AAAB, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h5555_5554, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h0F0F_0F0F, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'hF0F0_F0F0, 1'b0, no_rsp});
      dir_rows.push_back({KIND_ACQUIRE, 32'h1234_5678, 1'b0, no_rsp});
      // table full: nothing changes
      dir_rows.push_back({KIND_ACQUIRE, 32'hDEAD_BEEF, 1'b1, 4'd0, 16'd0, ST_FULL});
      dir_rows.push_back({KIND_RELEASE, 32'h0000_0000, 1'b1, 4'd0, 16'd0, ST_FREED});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_op(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed,
                 dir_rows[i].rsp, $urandom_range(0, 4));
      end

      // Key pool: half random, half one bit away from a random key, so the
      // compare is exercised on near misses. 20 keys > 16 slots to hit full.
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < POOL_SIZE / 2) key_pool[i] = $urandom;
         else key_pool[i] = key_pool[i - POOL_SIZE / 2] ^ (32'd1 << $urandom_range(0, 31));
      end

      // Random part: phases alternate between filling and draining the table.
      idle_on = 1'b1;
      acq_heavy = 1'b1;
      for (int n = 0; n < RAND_OPS; n++) begin
         if (n % PHASE_OPS == 0) begin
            acq_heavy = ((n / PHASE_OPS) % 2 == 0);
            idle_on = ($urandom_range(0, 3) != 0);
         end
         kind = ($urandom_range(0, 99) < (acq_heavy ? 75 : 25)) ? KIND_ACQUIRE : KIND_RELEASE;
         sel = $urandom_range(0, 99);
         if (kind == KIND_ACQUIRE) begin
            key = (sel < 90) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
         end else begin
            live_idx = {};
            for (int i = 0; i < SLOTS; i++) if (shadow_cnt[i] != '0) live_idx.push_back(i);
            if (sel < 50) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (sel < 85 && live_idx.size() > 0)
               key = shadow_key[live_idx[$urandom_range(0, live_idx.size() - 1)]];
            else key = $urandom;
         end
         gap = idle_on ? $urandom_range(0, 4) : 0;
         send_op(kind, key, 1'b0, no_rsp, gap);
      end
      start <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (awaited_rsp_q.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);

      if (mismatches == 0 && awaited_rsp_q.size() == 0) begin
         $display("tb_refcounted_key_intern_table: PASS");
      end else begin
         $display("tb_refcounted_key_intern_table: FAIL");
      end
      $finish;
   end

endmodule
